FILE: rtl/spqu_pkg.sv
package spqu_pkg;

  // Default number of queue slots.
  localparam int DEFAULT_QUEUE_DEPTH = 16;

  // Operation codes carried by an input transaction.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_UNDO   = 2'd2;
  localparam logic [1:0] OP_DUMP   = 2'd3;

  // Status codes carried by a result transaction.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_NO_UNDO = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] item_tag;
    logic [7:0]  priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_tag;
    logic [7:0]  out_priority;
    logic        last;
  } out_item_t;

  // One stored queue entry.
  typedef struct packed {
    logic [15:0] tag;
    logic [7:0]  pri;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;      // latch a new request, clear the walk index
    logic       carry_saved; // on accept, load the carry entry from the undo register
    logic       rd;          // read the slot at the walk index
    logic       wr;          // write the carry entry
    logic       wr_front;    // write in front of the head and move the head back
    logic       carry_rd;    // load the carry entry from the read data
    logic       idx_inc;     // advance the walk index
    logic       cnt_inc;     // one more entry in the queue
    logic       pop;         // save the read head entry and advance the head
    logic       clr_saved;   // undo register consumed
    logic       out_load;    // load the result register
    logic [1:0] res_status;
    logic       res_data;    // result shows the read entry
    logic       res_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic saved_valid;
    logic idx_end;   // walk index equals the entry count
    logic idx_last;  // walk index is the last entry
    logic rd_lt;     // read priority below the carry priority
    logic rd_gt;     // read priority above the carry priority
    logic out_free;  // result register can take a new transaction
  } sts_t;

endpackage

FILE: rtl/spqu_ctrl.sv
module spqu_ctrl import spqu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_stall,
  input  sts_t       sts,
  output cmd_t       cmd
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_INS_EV0 = 11'b000_0000_0010,
    S_INS_RD  = 11'b000_0000_0100,
    S_INS_EV  = 11'b000_0000_1000,
    S_SH_RD   = 11'b000_0001_0000,
    S_SH_EV   = 11'b000_0010_0000,
    S_FRONT   = 11'b000_0100_0000,
    S_POP_EV  = 11'b000_1000_0000,
    S_DMP_EV  = 11'b001_0000_0000,
    S_DMP_RD  = 11'b010_0000_0000,
    S_RESP    = 11'b100_0000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] op_r, op_nxt;
  logic [1:0] res_st_r, res_st_nxt;
  logic       res_dat_r, res_dat_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Sequencing of one request through the queue memory.
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    res_st_nxt  = res_st_r;
    res_dat_nxt = res_dat_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept      = 1'b1;
          cmd.rd          = 1'b1;
          cmd.carry_saved = (in_op == OP_UNDO);
          op_nxt          = in_op;
          res_st_nxt      = ST_OK;
          res_dat_nxt     = 1'b0;
          unique case (in_op)
            OP_INSERT: begin
              if (sts.full) begin
                res_st_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end else if (sts.empty) begin
                state_nxt = S_FRONT;
              end else begin
                state_nxt = S_INS_EV0;
              end
            end
            OP_POP: begin
              if (sts.empty) begin
                res_st_nxt = ST_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_POP_EV;
              end
            end
            OP_UNDO: begin
              if (!sts.saved_valid) begin
                res_st_nxt = ST_NO_UNDO;
                state_nxt  = S_RESP;
              end else if (sts.full) begin
                res_st_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_FRONT;
              end
            end
            default: begin
              if (sts.empty) begin
                res_st_nxt = ST_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_DMP_EV;
              end
            end
          endcase
        end
      end
      // The head decides between going in front and walking the list.
      S_INS_EV0: begin
        if (!sts.rd_lt) begin
          state_nxt = S_FRONT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (sts.idx_end) begin
          cmd.wr      = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_RESP;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_INS_EV;
        end
      end
      // The first entry with a higher priority gives up its slot.
      S_INS_EV: begin
        cmd.idx_inc = 1'b1;
        if (sts.rd_gt) begin
          cmd.wr       = 1'b1;
          cmd.carry_rd = 1'b1;
          state_nxt    = S_SH_RD;
        end else begin
          state_nxt = S_INS_RD;
        end
      end
      // Ripple the displaced entries one slot toward the tail.
      S_SH_RD: begin
        if (sts.idx_end) begin
          cmd.wr      = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_RESP;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_SH_EV;
        end
      end
      S_SH_EV: begin
        cmd.wr       = 1'b1;
        cmd.carry_rd = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_nxt    = S_SH_RD;
      end
      S_FRONT: begin
        cmd.wr        = 1'b1;
        cmd.wr_front  = 1'b1;
        cmd.cnt_inc   = 1'b1;
        cmd.clr_saved = (op_r == OP_UNDO);
        state_nxt     = S_RESP;
      end
      S_POP_EV: begin
        cmd.pop     = 1'b1;
        res_dat_nxt = 1'b1;
        state_nxt   = S_RESP;
      end
      // Dump sends one transaction per entry as the result register frees up.
      S_DMP_EV: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_data   = 1'b1;
          cmd.res_last   = sts.idx_last;
          if (sts.idx_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_DMP_RD;
          end
        end
      end
      S_DMP_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_DMP_EV;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.res_status = res_st_r;
          cmd.res_data   = res_dat_r;
          cmd.res_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and request registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    res_st_r  <= res_st_nxt;
    res_dat_r <= res_dat_nxt;
  end

endmodule

FILE: rtl/spqu_dpath.sv
module spqu_dpath import spqu_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_data,
  input  cmd_t      cmd,
  output sts_t      sts
);

  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;

  // Queue storage, a ring with the head at head_r.
  entry_t mem [QUEUE_DEPTH];

  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r;
  entry_t            carry_r;
  entry_t            saved_r;
  logic              saved_valid_r, saved_valid_nxt;
  entry_t            rd_data_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [SUM_W-1:0]  idx_sum;
  logic [ADDR_W-1:0] idx_addr;
  logic [ADDR_W-1:0] head_inc;
  logic [ADDR_W-1:0] head_dec;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [CNT_W:0]    idx_plus1;

  // Slot of the walk index, wrapped around the ring.
  assign idx_sum  = SUM_W'(head_r) + SUM_W'(idx_r);
  assign idx_addr = (idx_sum >= SUM_W'(QUEUE_DEPTH)) ?
                    ADDR_W'(idx_sum - SUM_W'(QUEUE_DEPTH)) : ADDR_W'(idx_sum);
  assign head_inc = (head_r == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? ADDR_W'(QUEUE_DEPTH - 1) : head_r - 1'b1;
  assign rd_addr  = cmd.accept ? head_r : idx_addr;
  assign wr_addr  = cmd.wr_front ? head_dec : idx_addr;

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= carry_r;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Head, count and undo flag updates.
  always_comb begin
    head_nxt        = head_r;
    count_nxt       = count_r;
    saved_valid_nxt = saved_valid_r;
    if (cmd.wr_front) begin
      head_nxt = head_dec;
    end
    if (cmd.pop) begin
      head_nxt        = head_inc;
      count_nxt       = count_r - 1'b1;
      saved_valid_nxt = 1'b1;
    end
    if (cmd.cnt_inc) begin
      count_nxt = count_r + 1'b1;
    end
    if (cmd.clr_saved) begin
      saved_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      count_r       <= '0;
      saved_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      head_r        <= head_nxt;
      count_r       <= count_nxt;
      saved_valid_r <= saved_valid_nxt;
      out_valid_r   <= cmd.out_load | (out_valid_r & out_stall);
    end
  end

  // Walk index, carry entry, undo copy and result payload.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.accept) begin
      if (cmd.carry_saved) begin
        carry_r <= saved_r;
      end else begin
        carry_r <= '{tag: in_data.item_tag, pri: in_data.priority_req};
      end
    end else if (cmd.carry_rd) begin
      carry_r <= rd_data_r;
    end
    if (cmd.pop) begin
      saved_r <= rd_data_r;
    end
    if (cmd.out_load) begin
      out_data_r.status       <= cmd.res_status;
      out_data_r.out_tag      <= cmd.res_data ? rd_data_r.tag : '0;
      out_data_r.out_priority <= cmd.res_data ? rd_data_r.pri : '0;
      out_data_r.last         <= cmd.res_last;
    end
  end

  assign idx_plus1 = (CNT_W + 1)'(idx_r) + 1'b1;

  // Status toward the controller.
  assign sts.empty       = (count_r == '0);
  assign sts.full        = (count_r == CNT_W'(QUEUE_DEPTH));
  assign sts.saved_valid = saved_valid_r;
  assign sts.idx_end     = (idx_r == count_r);
  assign sts.idx_last    = (idx_plus1 == (CNT_W + 1)'(count_r));
  assign sts.rd_lt       = (rd_data_r.pri < carry_r.pri);
  assign sts.rd_gt       = (rd_data_r.pri > carry_r.pri);
  assign sts.out_free    = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/sorted_priority_queue_with_undo.sv
// Accept to result load: pop via S_POP_EV; undo and insert into an empty queue via S_FRONT;
// insert at the head via S_INS_EV0 and S_FRONT; other inserts walk the list via read and
// evaluate states; refused requests go straight to S_RESP; dump loads one result per entry,
// reading each entry in between. One request at a time, the next taken in the cycle after
// its last result loads, paced by the memory walk and held by a stalled result register.
// Synchronous active-low reset empties the queue, drops the undo copy and clears out_valid.
module sorted_priority_queue_with_undo import spqu_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  cmd_t cmd;
  sts_t sts;

  // Request sequencing.
  spqu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Entry storage, pointers and result register.
  spqu_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

FILE: rtl/spqu_checker.sv
module spqu_checker import spqu_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The block works on one request at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another was in progress");

  // Only a dump gives results that are not last, and those are all successful.
  a_not_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.status == ST_OK)
    else $error("non-final result with an error status");

  // Error results carry no entry.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.out_tag == '0 && out_data.out_priority == '0)
    else $error("error result carries entry data");

endmodule

bind sorted_priority_queue_with_undo spqu_checker u_spqu_checker (.*);

FILE: sim/sorted_priority_queue_with_undo_checker.sv
module sorted_priority_queue_with_undo_checker import spqu_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending_results,
  output int        results_checked,
  output int        full_drops,
  output int        undos_applied
);

  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the queue, head at index 0, plus the undo register.
  entry_t    ordered_entries[$];
  entry_t    saved_entry;
  bit        saved_valid;
  out_item_t awaited_results[$];

  // Update the shadow queue for one accepted request and queue the results it causes.
  task automatic apply_request(input in_item_t req);
    out_item_t res;
    entry_t    fresh;
    int        pos;
    res = '0;
    res.last = 1'b1;
    case (req.operation)
      OP_INSERT: begin
        if (ordered_entries.size() >= QUEUE_DEPTH) begin
          res.status = ST_FULL;
          full_drops++;
        end else begin
          fresh.tag = req.item_tag;
          fresh.pri = req.priority_req;
          // The walk passes the head only if it is below the new priority, then stops at the first above.
          if (ordered_entries.size() == 0 || req.priority_req <= ordered_entries[0].pri) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < ordered_entries.size() && ordered_entries[pos].pri <= req.priority_req)
              pos++;
          end
          ordered_entries.insert(pos, fresh);
          res.status = ST_OK;
        end
        awaited_results.push_back(res);
      end
      OP_POP: begin
        if (ordered_entries.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          saved_entry      = ordered_entries.pop_front();
          saved_valid      = 1'b1;
          res.status       = ST_OK;
          res.out_tag      = saved_entry.tag;
          res.out_priority = saved_entry.pri;
        end
        awaited_results.push_back(res);
      end
      OP_UNDO: begin
        if (!saved_valid) begin
          res.status = ST_NO_UNDO;
        end else if (ordered_entries.size() >= QUEUE_DEPTH) begin
          // A full queue drops the undo but keeps the saved copy.
          res.status = ST_FULL;
          full_drops++;
        end else begin
          ordered_entries.push_front(saved_entry);
          saved_valid = 1'b0;
          res.status  = ST_OK;
          undos_applied++;
        end
        awaited_results.push_back(res);
      end
      default: begin
        if (ordered_entries.size() == 0) begin
          res.status = ST_EMPTY;
          awaited_results.push_back(res);
        end else begin
          foreach (ordered_entries[i]) begin
            res.status       = ST_OK;
            res.out_tag      = ordered_entries[i].tag;
            res.out_priority = ordered_entries[i].pri;
            res.last         = (i == ordered_entries.size() - 1);
            awaited_results.push_back(res);
          end
        end
      end
    endcase
  endtask

  // Compare one accepted result against the oldest expectation.
  task automatic compare_result(input out_item_t got);
    out_item_t want;
    if (awaited_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result: status %0d tag %h pri %h last %0d",
                 got.status, got.out_tag, got.out_priority, got.last);
    end else begin
      want = awaited_results.pop_front();
      if (got.status !== want.status || got.out_tag !== want.out_tag ||
          got.out_priority !== want.out_priority || got.last !== want.last) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result %0d wrong: expected status %0d tag %h pri %h last %0d,",
                   results_checked, want.status, want.out_tag, want.out_priority, want.last,
                   " got status %0d tag %h pri %h last %0d",
                   got.status, got.out_tag, got.out_priority, got.last);
      end
    end
    results_checked++;
  endtask

  // Watch both channels; a request cannot produce its result in the same cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      ordered_entries.delete();
      awaited_results.delete();
      saved_valid = 1'b0;
      saved_entry = '0;
    end else begin
      if (in_valid && !in_stall)
        apply_request(in_data);
      if (out_valid && !out_stall)
        compare_result(out_data);
    end
    pending_results <= awaited_results.size();
  end

endmodule

FILE: sim/sorted_priority_queue_with_undo_test.sv
module sorted_priority_queue_with_undo_test import spqu_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH    = DEFAULT_QUEUE_DEPTH;
  localparam int RANDOM_ITEMS   = 140;
  localparam int SETTLE_CYCLES  = 2 * QUEUE_DEPTH + 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AT        = 45;
  localparam int CALM_FROM      = 90;
  localparam int CALM_TO        = 130;
  localparam int PAUSE_AT       = 150;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int fail_count;
  int pending_results;
  int results_checked;
  int full_drops;
  int undos_applied;
  int requests_sent;
  int op_counts[4];

  sorted_priority_queue_with_undo #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  sorted_priority_queue_with_undo_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) checker_inst (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending_results(pending_results),
    .results_checked(results_checked),
    .full_drops     (full_drops),
    .undos_applied  (undos_applied)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one request, with random idle cycles ahead of it outside the calm window,
  // and hold it until the block takes the transaction.
  task automatic offer_request(input logic [1:0] op, input logic [15:0] tag,
                               input logic [7:0] pri);
    bit calm;
    calm = (requests_sent >= CALM_FROM && requests_sent < CALM_TO);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{operation: op, item_tag: tag, priority_req: pri};
    do @(posedge clk); while (in_stall);
    requests_sent++;
    op_counts[op]++;
  endtask

  // Result side: random stalls, one long hold-off that holds back the requests,
  // and a stretch with no stalls.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && requests_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (requests_sent >= CALM_FROM && requests_sent < CALM_TO) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 30);
      end
    end
  end

  // Watchdog: too many cycles in a row without any transaction ends the run.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", pending_results);
        $display("sorted_priority_queue_with_undo: mismatch");
        $finish;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [1:0] op;
    logic [7:0] pri;
    int         pick;
    bit         filling;
    requests_sent = 0;
    foreach (op_counts[i]) op_counts[i] = 0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty-queue corner cases.
    offer_request(OP_DUMP,   16'h0000, 8'h00);
    offer_request(OP_POP,    16'hFFFF, 8'hFF);
    offer_request(OP_UNDO,   16'hFFFF, 8'hFF);
    // Extreme tags and priorities, ties in the middle and at the head.
    offer_request(OP_INSERT, 16'h0000, 8'h00);
    offer_request(OP_INSERT, 16'hFFFF, 8'hFF);
    offer_request(OP_INSERT, 16'h1234, 8'h80);
    offer_request(OP_INSERT, 16'h4321, 8'h80);
    offer_request(OP_INSERT, 16'hA5A5, 8'h00);
    offer_request(OP_DUMP,   16'hFFFF, 8'hFF);
    // A second pop replaces the saved entry; undo works only once.
    offer_request(OP_POP,    16'h0000, 8'h00);
    offer_request(OP_POP,    16'h0000, 8'h00);
    offer_request(OP_UNDO,   16'h0000, 8'h00);
    offer_request(OP_UNDO,   16'h0000, 8'h00);
    // Undo after a lower insert leaves the queue out of order; inserts still walk from the head.
    offer_request(OP_POP,    16'h0000, 8'h00);
    offer_request(OP_POP,    16'h0000, 8'h00);
    offer_request(OP_INSERT, 16'h5A5A, 8'h10);
    offer_request(OP_UNDO,   16'h0000, 8'h00);
    offer_request(OP_INSERT, 16'h0F0F, 8'h40);
    offer_request(OP_INSERT, 16'hF0F0, 8'h90);
    offer_request(OP_DUMP,   16'h0000, 8'h00);

    // Random part: alternating fill-heavy and drain-heavy stretches reach the full
    // and empty corners, with undo sprinkled in.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (requests_sent == PAUSE_AT) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
      end
      filling = ((n / 40) % 2 == 0);
      pick = $urandom_range(99);
      if (filling)
        op = (pick < 60) ? OP_INSERT : (pick < 75) ? OP_POP : (pick < 90) ? OP_UNDO : OP_DUMP;
      else
        op = (pick < 20) ? OP_INSERT : (pick < 70) ? OP_POP : (pick < 85) ? OP_UNDO : OP_DUMP;
      // Half the priorities come from a narrow band so that ties are common.
      pri = ($urandom_range(1) == 0) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
      offer_request(op, 16'($urandom), pri);
    end
    in_valid <= 1'b0;

    // Drain, then give the block time to show any stray result.
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (pending_results != 0)
      $display("%0d expected results never arrived", pending_results);
    $display("Sent %0d requests (%0d insert, %0d pop, %0d undo, %0d dump); checked %0d results.",
             requests_sent, op_counts[OP_INSERT], op_counts[OP_POP], op_counts[OP_UNDO],
             op_counts[OP_DUMP], results_checked);
    $display("Full-queue drops seen: %0d, undos restored: %0d, failures: %0d.",
             full_drops, undos_applied, fail_count);
    if (fail_count == 0 && pending_results == 0) begin
      $display("sorted_priority_queue_with_undo: match");
    end else begin
      $display("sorted_priority_queue_with_undo: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/spqu_pkg.sv
rtl/spqu_ctrl.sv
rtl/spqu_dpath.sv
rtl/sorted_priority_queue_with_undo.sv
rtl/spqu_checker.sv
sim/sorted_priority_queue_with_undo_checker.sv
sim/sorted_priority_queue_with_undo_test.sv
